FILE: hdl/zibsu_pkg.sv
package zibsu_pkg;

  // Opcode bits 7:6.
  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } group_t;

  // Opcode bits 5:3 within the shift group.
  typedef enum logic [2:0] {
    SH_RLC = 3'd0,
    SH_RRC = 3'd1,
    SH_RL  = 3'd2,
    SH_RR  = 3'd3,
    SH_SLA = 3'd4,
    SH_SRA = 3'd5,
    SH_SLL = 3'd6,
    SH_SRL = 3'd7
  } shift_t;

  // Register code that names (HL)-style memory: no register copy.
  localparam logic [2:0] REG_CODE_MEM = 3'd6;

  // Flag bit positions, S Z X5 H X3 P N C from bit 7 down.
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_X5 = 5;
  localparam int FLAG_H  = 4;
  localparam int FLAG_X3 = 3;
  localparam int FLAG_P  = 2;
  localparam int FLAG_N  = 1;
  localparam int FLAG_C  = 0;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] index_base;
    logic [7:0]  displacement;
    logic [7:0]  mem_byte;
    logic        carry_in;
  } item_t;

  typedef struct packed {
    logic [15:0] address;
    logic        mem_write;
    logic [7:0]  write_byte;
    logic [7:0]  flags_out;
    logic        flags_write;
    logic [2:0]  reg_select;
    logic        reg_write;
  } result_t;

endpackage

FILE: hdl/zibsu_exec.sv
module zibsu_exec (
  input  zibsu_pkg::item_t   item,
  output zibsu_pkg::result_t res
);

  logic [2:0]  sel;
  logic [1:0]  grp;
  logic [7:0]  mask;
  logic [7:0]  m;
  logic [15:0] addr;
  logic [7:0]  sh_byte;
  logic        sh_cout;
  logic [7:0]  tested;

  assign grp    = item.opcode[7:6];
  assign sel    = item.opcode[5:3];
  assign m      = item.mem_byte;
  assign mask   = 8'd1 << sel;
  assign addr   = item.index_base + {{8{item.displacement[7]}}, item.displacement};
  assign tested = m & mask;

  always_comb begin
    case (zibsu_pkg::shift_t'(sel))
      zibsu_pkg::SH_RLC: begin sh_cout = m[7]; sh_byte = {m[6:0], m[7]}; end
      zibsu_pkg::SH_RRC: begin sh_cout = m[0]; sh_byte = {m[0], m[7:1]}; end
      zibsu_pkg::SH_RL:  begin sh_cout = m[7]; sh_byte = {m[6:0], item.carry_in}; end
      zibsu_pkg::SH_RR:  begin sh_cout = m[0]; sh_byte = {item.carry_in, m[7:1]}; end
      zibsu_pkg::SH_SLA: begin sh_cout = m[7]; sh_byte = {m[6:0], 1'b0}; end
      zibsu_pkg::SH_SRA: begin sh_cout = m[0]; sh_byte = {m[7], m[7:1]}; end
      zibsu_pkg::SH_SLL: begin sh_cout = m[7]; sh_byte = {m[6:0], 1'b1}; end
      default:           begin sh_cout = m[0]; sh_byte = {1'b0, m[7:1]}; end
    endcase
  end

  always_comb begin
    res.address     = addr;
    res.reg_select  = item.opcode[2:0];
    res.reg_write   = (item.opcode[2:0] != zibsu_pkg::REG_CODE_MEM);
    res.mem_write   = 1'b1;
    res.write_byte  = m;
    res.flags_out   = 8'h00;
    res.flags_write = 1'b0;
    case (zibsu_pkg::group_t'(grp))
      zibsu_pkg::GRP_SHIFT: begin
        res.write_byte                  = sh_byte;
        res.flags_write                 = 1'b1;
        res.flags_out[zibsu_pkg::FLAG_S]  = sh_byte[7];
        res.flags_out[zibsu_pkg::FLAG_Z]  = (sh_byte == 8'h00);
        res.flags_out[zibsu_pkg::FLAG_X5] = sh_byte[5];
        res.flags_out[zibsu_pkg::FLAG_X3] = sh_byte[3];
        res.flags_out[zibsu_pkg::FLAG_P]  = ~^sh_byte;
        res.flags_out[zibsu_pkg::FLAG_C]  = sh_cout;
      end
      zibsu_pkg::GRP_BIT: begin
        // BIT takes X5 and X3 from the high byte of the effective address.
        res.mem_write                     = 1'b0;
        res.reg_write                     = 1'b0;
        res.flags_write                   = 1'b1;
        res.flags_out[zibsu_pkg::FLAG_S]  = tested[7];
        res.flags_out[zibsu_pkg::FLAG_Z]  = (tested == 8'h00);
        res.flags_out[zibsu_pkg::FLAG_X5] = addr[13];
        res.flags_out[zibsu_pkg::FLAG_H]  = 1'b1;
        res.flags_out[zibsu_pkg::FLAG_X3] = addr[11];
        res.flags_out[zibsu_pkg::FLAG_P]  = (tested == 8'h00);
        res.flags_out[zibsu_pkg::FLAG_C]  = item.carry_in;
      end
      zibsu_pkg::GRP_RES: begin
        res.write_byte = m & ~mask;
      end
      default: begin
        res.write_byte = m | mask;
      end
    endcase
  end

endmodule

FILE: hdl/z80_indexed_bit_shift_unit.sv
// An accepted word is held in the input register, then offered from the result register.
// Throughput: one word per cycle, sustained while the result side keeps taking words.
// The path is an input register, the execute logic (address add, shift or bit op, flags),
// and a result register; each register holds its word while the stage after it stalls.
// Reset (rst_n low, synchronous) empties both registers; payload contents are not cleared.
module z80_indexed_bit_shift_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_opcode,
  input  logic [15:0]        in_index_base,
  input  logic signed [7:0]  in_displacement,
  input  logic [7:0]         in_mem_byte,
  input  logic               in_carry_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_address,
  output logic               out_mem_write,
  output logic [7:0]         out_write_byte,
  output logic [7:0]         out_flags_out,
  output logic               out_flags_write,
  output logic [2:0]         out_reg_select,
  output logic               out_reg_write
);

  // Input stage: captures the incoming word.
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  zibsu_pkg::item_t    s1_item_r;
  logic                s1_adv;

  // Result stage: holds the finished word until the consumer takes it.
  logic                out_valid_r;
  logic                out_valid_nxt;
  zibsu_pkg::result_t  out_res_r;
  zibsu_pkg::result_t  exec_res;
  logic                out_load;

  // The result register can take a new word when it is empty or is being drained
  // this cycle; the input register frees up whenever its word moves forward.
  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !out_load);
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  zibsu_exec u_exec (
    .item (s1_item_r),
    .res  (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.opcode       <= in_opcode;
      s1_item_r.index_base   <= in_index_base;
      s1_item_r.displacement <= in_displacement;
      s1_item_r.mem_byte     <= in_mem_byte;
      s1_item_r.carry_in     <= in_carry_in;
    end
    if (s1_adv) begin
      out_res_r <= exec_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_address     = out_res_r.address;
  assign out_mem_write   = out_res_r.mem_write;
  assign out_write_byte  = out_res_r.write_byte;
  assign out_flags_out   = out_res_r.flags_out;
  assign out_flags_write = out_res_r.flags_write;
  assign out_reg_select  = out_res_r.reg_select;
  assign out_reg_write   = out_res_r.reg_write;

endmodule

FILE: bench/z80_indexed_bit_shift_unit_checker.sv
`timescale 1ns / 1ps

module z80_indexed_bit_shift_unit_checker
  import zibsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_opcode,
  input  logic [15:0]       in_index_base,
  input  logic signed [7:0] in_displacement,
  input  logic [7:0]        in_mem_byte,
  input  logic              in_carry_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_address,
  input  logic              out_mem_write,
  input  logic [7:0]        out_write_byte,
  input  logic [7:0]        out_flags_out,
  input  logic              out_flags_write,
  input  logic [2:0]        out_reg_select,
  input  logic              out_reg_write,
  output int                fail_count,
  output int                pending_count,
  output int                words_checked
);

  result_t pending_results[$];
  item_t   seen_word;
  result_t want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    words_checked = 0;
  end

  // Executes one indexed CB instruction on the word as the block should.
  function automatic result_t execute_indexed_op(item_t w);
    result_t    r;
    group_t     grp;
    logic [2:0] sel;
    logic [7:0] m;
    logic [7:0] mask;
    logic [7:0] wb;
    logic [7:0] tested;
    logic       cout;
    grp  = group_t'(w.opcode[7:6]);
    sel  = w.opcode[5:3];
    m    = w.mem_byte;
    mask = 8'h01 << sel;
    wb   = m;
    cout = 1'b0;
    r.address     = w.index_base + {{8{w.displacement[7]}}, w.displacement};
    r.reg_select  = w.opcode[2:0];
    r.reg_write   = (w.opcode[2:0] != REG_CODE_MEM);
    r.mem_write   = 1'b1;
    r.flags_write = 1'b0;
    r.flags_out   = 8'h00;
    case (grp)
      GRP_SHIFT: begin
        case (shift_t'(sel))
          SH_RLC:  {cout, wb} = {m[7], m[6:0], m[7]};
          SH_RRC:  {wb, cout} = {m[0], m[7:1], m[0]};
          SH_RL:   {cout, wb} = {m, w.carry_in};
          SH_RR:   {wb, cout} = {w.carry_in, m};
          SH_SLA:  {cout, wb} = {m, 1'b0};
          SH_SRA:  {wb, cout} = {m[7], m};
          SH_SLL:  {cout, wb} = {m, 1'b1};
          default: {wb, cout} = {1'b0, m};
        endcase
        r.flags_out[FLAG_S]  = wb[7];
        r.flags_out[FLAG_Z]  = (wb == 8'h00);
        r.flags_out[FLAG_X5] = wb[5];
        r.flags_out[FLAG_X3] = wb[3];
        r.flags_out[FLAG_P]  = ~^wb;
        r.flags_out[FLAG_C]  = cout;
        r.flags_write = 1'b1;
      end
      GRP_BIT: begin
        tested = m & mask;
        r.flags_out[FLAG_S]  = tested[7];
        r.flags_out[FLAG_Z]  = (tested == 8'h00);
        r.flags_out[FLAG_P]  = (tested == 8'h00);
        r.flags_out[FLAG_X5] = r.address[13];
        r.flags_out[FLAG_X3] = r.address[11];
        r.flags_out[FLAG_H]  = 1'b1;
        r.flags_out[FLAG_C]  = w.carry_in;
        r.flags_write = 1'b1;
        r.mem_write   = 1'b0;
        r.reg_write   = 1'b0;
      end
      GRP_RES: wb = m & ~mask;
      default: wb = m | mask;
    endcase
    r.write_byte = wb;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
             exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen_word.opcode       = in_opcode;
        seen_word.index_base   = in_index_base;
        seen_word.displacement = in_displacement;
        seen_word.mem_byte     = in_mem_byte;
        seen_word.carry_in     = in_carry_in;
        pending_results.push_back(execute_indexed_op(seen_word));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", int'(out_address), 0);
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (out_address !== want.address)
            report_mismatch("address", int'(out_address), int'(want.address));
          if (out_mem_write !== want.mem_write)
            report_mismatch("mem_write", int'(out_mem_write), int'(want.mem_write));
          if (out_write_byte !== want.write_byte)
            report_mismatch("write_byte", int'(out_write_byte), int'(want.write_byte));
          if (out_flags_out !== want.flags_out)
            report_mismatch("flags_out", int'(out_flags_out), int'(want.flags_out));
          if (out_flags_write !== want.flags_write)
            report_mismatch("flags_write", int'(out_flags_write), int'(want.flags_write));
          if (out_reg_select !== want.reg_select)
            report_mismatch("reg_select", int'(out_reg_select), int'(want.reg_select));
          if (out_reg_write !== want.reg_write)
            report_mismatch("reg_write", int'(out_reg_write), int'(want.reg_write));
        end
      end
      pending_count = pending_results.size();
    end
  end

endmodule

FILE: bench/z80_indexed_bit_shift_unit_tb.sv
`timescale 1ns / 1ps

module z80_indexed_bit_shift_unit_tb;
  import zibsu_pkg::*;

  // Run shape. The random part is split into phases so that idling, the long
  // receiver hold-off and the drain pause each get a stretch of their own.
  localparam int NUM_RANDOM_WORDS = 1250;
  localparam int WORDS_PER_PHASE  = 250;
  localparam int HOLD_OFF_CYCLES  = 150;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RESET_CYCLES     = 11;
  // The slowest correct run is roughly 1300 words with idling on both sides plus
  // the hold-off; this limit is over ten times that.
  localparam int RUN_LIMIT_NS     = 5_000_000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_opcode;
  logic [15:0]       in_index_base;
  logic signed [7:0] in_displacement;
  logic [7:0]        in_mem_byte;
  logic              in_carry_in;
  logic              out_valid;
  logic              out_ready;
  logic [15:0]       out_address;
  logic              out_mem_write;
  logic [7:0]        out_write_byte;
  logic [7:0]        out_flags_out;
  logic              out_flags_write;
  logic [2:0]        out_reg_select;
  logic              out_reg_write;

  int fail_count;
  int pending_count;
  int words_checked;

  // When set, the matching side runs without any idle cycles between words.
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit long_hold   = 1'b0;

  always #6 clk = ~clk;

  z80_indexed_bit_shift_unit dut (.*);

  z80_indexed_bit_shift_unit_checker checker_i (.*);

  // Builds one input word from its fields.
  function automatic item_t make_word(logic [7:0] op, logic [15:0] base, logic [7:0] disp,
                                      logic [7:0] mem, logic cin);
    item_t w;
    w.opcode       = op;
    w.index_base   = base;
    w.displacement = disp;
    w.mem_byte     = mem;
    w.carry_in     = cin;
    return w;
  endfunction

  // A random instruction. Every field is drawn over its whole range, with a
  // bias now and then toward the corner bytes and index values, where the
  // shifts carry out and the address add wraps.
  function automatic item_t random_word();
    item_t w;
    int    pick;
    w = make_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       w.mem_byte = 8'h00;
        1:       w.mem_byte = 8'hFF;
        2:       w.mem_byte = 8'h80;
        default: w.mem_byte = 8'h01;
      endcase
    end else if (pick == 1) begin
      w.index_base = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      w.displacement = $urandom_range(0, 1) ? 8'h7F : 8'h80;
    end
    return w;
  endfunction

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // Offers one word and returns at the clock edge where it was taken. The
  // ready line only moves at rising edges, so sampling it at the falling edge
  // tells whether the coming rising edge completes the handshake. Valid is
  // only lowered when there is a gap, so it never drops and rises in one step.
  task automatic send_word(input item_t w);
    int gap;
    bit took;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= w.opcode;
    in_index_base   <= w.index_base;
    in_displacement <= w.displacement;
    in_mem_byte     <= w.mem_byte;
    in_carry_in     <= w.carry_in;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Stops offering words and waits until every expected result word has come.
  // The falling edge lets the checker count the word taken at the last edge.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  // Result side: draws a stall for each word, and once on request holds off
  // for a long stretch so that the block fills and pushes back on its input.
  initial begin
    bit took;
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = draw_gap(recv_steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= 8'h00;
    in_index_base   <= 16'h0000;
    in_displacement <= 8'h00;
    in_mem_byte     <= 8'h00;
    in_carry_in     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Every rotate and shift kind, first on bytes whose top or
    // bottom bit alone is set, then on all-zero and all-one bytes, with the
    // register code running through every value including the memory code.
    for (int k = 0; k < 8; k++) begin
      send_word(make_word({GRP_SHIFT, k[2:0], k[2:0]}, 16'h1234, 8'h05,
                          k[0] ? 8'h01 : 8'h80, k[1]));
    end
    for (int k = 0; k < 8; k++) begin
      send_word(make_word({GRP_SHIFT, k[2:0], 3'(7 - k)}, 16'h8000, 8'hFB,
                          k[0] ? 8'hFF : 8'h00, ~k[1]));
    end
    // BIT on a set top bit, so the sign flag comes from the tested bit; the
    // address has bits 13 and 11 set, which show up in the undocumented flags.
    send_word(make_word({GRP_BIT, 3'd7, 3'd0}, 16'h2800, 8'h00, 8'h80, 1'b1));
    // BIT on a clear bit: zero and parity both set, carry passed through.
    send_word(make_word({GRP_BIT, 3'd0, REG_CODE_MEM}, 16'h0000, 8'h80, 8'hFE, 1'b0));
    // Address wraps past the top here; the words just before and after wrap below zero.
    send_word(make_word({GRP_BIT, 3'd3, 3'd7}, 16'hFFFF, 8'h7F, 8'hFF, 1'b1));
    // RES clears a bit, SET sets one; flags are left alone.
    send_word(make_word({GRP_RES, 3'd7, REG_CODE_MEM}, 16'h0000, 8'h80, 8'hFF, 1'b1));
    send_word(make_word({GRP_SET, 3'd0, 3'd7}, 16'hFFFF, 8'h01, 8'h00, 1'b0));
    send_word(make_word({GRP_SET, 3'd4, 3'd5}, 16'h7FFF, 8'h7F, 8'hAA, 1'b1));

    // Random part, in phases: the first with no idling on either side, the
    // third with a steady sender against a long receiver hold-off, and the
    // fifth entered only after everything in flight has drained.
    for (int n = 0; n < NUM_RANDOM_WORDS; n++) begin
      if (n % WORDS_PER_PHASE == 0) begin
        phase = n / WORDS_PER_PHASE;
        if (phase == 4) pause_until_drained();
        send_steady = (phase == 0) || (phase == 2);
        recv_steady = (phase == 0);
        if (phase == 2) long_hold = 1'b1;
      end
      send_word(random_word());
    end

    // Wind down: stop offering, let the last result words out, then give
    // any stray word a few more cycles to show up.
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: every shift kind, BIT, RES and SET, address wrap,",
             words_checked);
    $display("register code 6, random idling, a long output hold-off and a full drain.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #RUN_LIMIT_NS;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/zibsu_pkg.sv
hdl/zibsu_exec.sv
hdl/z80_indexed_bit_shift_unit.sv
bench/z80_indexed_bit_shift_unit_checker.sv
bench/z80_indexed_bit_shift_unit_tb.sv
